### rtl/kdl_pkg.sv
// kdl_pkg: shared types, codes and constants of the keypad door lock controller.
// No dependencies; used by every other file of the block.
`default_nettype none

package kdl_pkg;

    localparam int KEY_DEPTH_DEF  = 16;
    localparam int LINE_DEPTH_DEF = 32;
    localparam int PASS_MAX       = 8;
    localparam int SYM_W          = 8;
    localparam int ELAPSED_W      = 17;
    localparam int CFG_IDX_W      = 2;

    localparam logic [15:0] OPEN_TIMEOUT_RST = 16'd5000;
    localparam logic [15:0] BEAT_PERIOD_RST  = 16'd1000;

    localparam logic [SYM_W-1:0] SYM_KEY_TERM = 8'h23;
    localparam logic [SYM_W-1:0] SYM_CR       = 8'h0D;
    localparam logic [SYM_W-1:0] SYM_LF       = 8'h0A;

    localparam logic [1:0] PRESS_SINGLE = 2'd1;
    localparam logic [1:0] PRESS_DOUBLE = 2'd2;

    localparam int CMD_LEN = 5;
    // element 0 is the first character
    localparam logic [CMD_LEN-1:0][SYM_W-1:0] CMD_OPEN  = {8'h23, 8'h2A, 8'h4F, 8'h2A, 8'h23};
    localparam logic [CMD_LEN-1:0][SYM_W-1:0] CMD_CLOSE = {8'h23, 8'h2A, 8'h43, 8'h2A, 8'h23};

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_KEY    = 2'd2,
        KIND_SERIAL = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_PASS_OPEN    = 4'd1,
        EV_DEBUG_OPEN   = 4'd2,
        EV_DEBUG_CLOSE  = 4'd3,
        EV_BUTTON_OPEN  = 4'd4,
        EV_BUTTON_CLOSE = 4'd5,
        EV_BUTTON_PERM  = 4'd6,
        EV_DENIED       = 4'd7,
        EV_TIMEOUT      = 4'd8
    } t_event;

    typedef enum logic [1:0] {
        DOOR_CLOSED = 2'd0,
        DOOR_TEMP   = 2'd1,
        DOOR_PERM   = 2'd2
    } t_door;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PASS_CHARS = 2'd0,
        CFG_PASS_LEN   = 2'd1,
        CFG_TIMEOUT    = 2'd2,
        CFG_PERIOD     = 2'd3
    } t_cfg_idx;

    typedef logic [PASS_MAX-1:0][SYM_W-1:0] t_bytes;

    // gathered sequence handed to the matcher; len is valid when over is low
    typedef struct packed {
        logic   fire;
        logic   over;
        logic   [3:0] len;
        t_bytes bytes;
    } t_judge_req;

    typedef struct packed {
        logic   door_open;
        t_door  door_mode;
        t_event event_res;
        logic   heartbeat_led;
    } t_status;

endpackage

`default_nettype wire

### rtl/kdl_if.sv
// kdl_if: valid/ready channel interfaces for input words, result words and config writes.
// Depends on kdl_pkg for field widths.
`default_nettype none

interface kdl_item_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [1:0]                  tap_count;
    logic [kdl_pkg::SYM_W-1:0]   symbol;

    modport source (output valid, output mode, output tap_count, output symbol, input ready);
    modport sink   (input valid, input mode, input tap_count, input symbol, output ready);
endinterface

interface kdl_result_if;
    logic       valid;
    logic       ready;
    logic       door_open;
    logic [1:0] door_mode;
    logic [3:0] event_res;
    logic       heartbeat_led;

    modport source (output valid, output door_open, output door_mode, output event_res,
                    output heartbeat_led, input ready);
    modport sink   (input valid, input door_open, input door_mode, input event_res,
                    input heartbeat_led, output ready);
endinterface

interface kdl_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kdl_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [63:0]                     wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/kdl_gather.sv
// kdl_gather: collects keypad keys or serial characters and raises a judge request.
// Depends on kdl_pkg. Only the first PASS_MAX bytes are kept; longer sequences never match.
`default_nettype none

module kdl_gather #(
    parameter int DEPTH     = kdl_pkg::KEY_DEPTH_DEF,
    parameter bit LINE_MODE = 1'b0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic                      i_sel,
    input  wire logic [kdl_pkg::SYM_W-1:0] i_sym,
    output kdl_pkg::t_judge_req            o_req
);

    localparam int CW = $clog2(DEPTH);
    localparam int XW = CW + 4;

    logic [CW-1:0]   r_count, n_count;
    kdl_pkg::t_bytes r_bytes, n_bytes;

    logic [XW-1:0] cnt_x;
    logic [XW-1:0] inc_x;
    logic [XW-1:0] len_x;
    logic [2:0]    wr_idx;
    logic          can_store;
    logic          fire;
    logic          term;
    kdl_pkg::t_bytes wr_bytes;

    always_comb begin
        cnt_x     = XW'(r_count);
        inc_x     = cnt_x + XW'(1);
        can_store = cnt_x < XW'(DEPTH - 1);
        wr_idx    = cnt_x[2:0];
        wr_bytes  = r_bytes;
        if (cnt_x < XW'(kdl_pkg::PASS_MAX)) begin
            wr_bytes[wr_idx] = i_sym;
        end
        n_count = r_count;
        n_bytes = r_bytes;
        len_x   = cnt_x;
        fire    = 1'b0;
        term    = 1'b0;
        if (LINE_MODE) begin
            term = (i_sym == kdl_pkg::SYM_CR) || (i_sym == kdl_pkg::SYM_LF);
            if (term) begin
                fire    = cnt_x != '0;
                n_count = '0;
            end else if (can_store) begin
                n_bytes = wr_bytes;
                n_count = inc_x[CW-1:0];
            end
        end else begin
            if (can_store) begin
                n_bytes = wr_bytes;
                len_x   = inc_x;
            end
            fire    = (i_sym == kdl_pkg::SYM_KEY_TERM) || (len_x >= XW'(DEPTH - 1));
            n_count = fire ? '0 : len_x[CW-1:0];
        end
    end

    always_comb begin
        o_req.fire  = i_sel && fire;
        o_req.over  = len_x > XW'(kdl_pkg::PASS_MAX);
        o_req.len   = len_x[3:0];
        o_req.bytes = n_bytes;
        if (LINE_MODE && term) begin
            o_req.bytes = r_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step && i_sel) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && i_sel) begin
            r_bytes <= n_bytes;
        end
    end

endmodule

`default_nettype wire

### rtl/kdl_match.sv
// kdl_match: compares a gathered sequence with the debug commands and the password.
// Depends on kdl_pkg. Purely combinational.
`default_nettype none

module kdl_match (
    input  kdl_pkg::t_judge_req i_req,
    input  wire logic [63:0]    i_pass_chars,
    input  wire logic [3:0]     i_pass_len,
    output kdl_pkg::t_event     o_verdict
);

    logic is_cmd_len;
    logic open_hit;
    logic close_hit;
    logic pass_hit;

    always_comb begin
        is_cmd_len = !i_req.over && (i_req.len == 4'(kdl_pkg::CMD_LEN));
        open_hit   = is_cmd_len;
        close_hit  = is_cmd_len;
        for (int i = 0; i < kdl_pkg::CMD_LEN; i++) begin
            open_hit  = open_hit && (i_req.bytes[i] == kdl_pkg::CMD_OPEN[i]);
            close_hit = close_hit && (i_req.bytes[i] == kdl_pkg::CMD_CLOSE[i]);
        end
        pass_hit = (i_pass_len != 4'd0) && (i_pass_len <= 4'(kdl_pkg::PASS_MAX))
                   && !i_req.over && (i_req.len == i_pass_len);
        for (int i = 0; i < kdl_pkg::PASS_MAX; i++) begin
            if (4'(i) < i_req.len) begin
                pass_hit = pass_hit && (i_req.bytes[i] == i_pass_chars[8*i +: 8]);
            end
        end
        if (open_hit) begin
            o_verdict = kdl_pkg::EV_DEBUG_OPEN;
        end else if (close_hit) begin
            o_verdict = kdl_pkg::EV_DEBUG_CLOSE;
        end else if (pass_hit) begin
            o_verdict = kdl_pkg::EV_PASS_OPEN;
        end else begin
            o_verdict = kdl_pkg::EV_DENIED;
        end
    end

endmodule

`default_nettype wire

### rtl/kdl_ctrl.sv
// kdl_ctrl: door state machine, open timer and heartbeat timer.
// Depends on kdl_pkg. Gives the status after the current word.
`default_nettype none

module kdl_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  kdl_pkg::t_kind       i_kind,
    input  wire logic [1:0]      i_press,
    input  wire logic            i_judge_fire,
    input  kdl_pkg::t_event      i_verdict,
    input  wire logic [15:0]     i_open_timeout,
    input  wire logic [15:0]     i_beat_period,
    output kdl_pkg::t_status     o_status
);

    typedef enum logic [2:0] {
        LK_CLOSED = 3'b001,
        LK_TEMP   = 3'b010,
        LK_PERM   = 3'b100
    } t_lock;

    localparam int EW = kdl_pkg::ELAPSED_W;

    t_lock          r_lock, n_lock;
    logic [EW-1:0]  r_open_elapsed, n_open_elapsed;
    logic [EW-1:0]  r_beat_elapsed, n_beat_elapsed;
    logic           r_beat_level, n_beat_level;
    logic [EW-1:0]  open_inc;
    logic [EW-1:0]  beat_inc;
    kdl_pkg::t_event ev;

    always_comb begin
        open_inc       = (&r_open_elapsed) ? r_open_elapsed : r_open_elapsed + EW'(1);
        beat_inc       = (&r_beat_elapsed) ? r_beat_elapsed : r_beat_elapsed + EW'(1);
        n_lock         = r_lock;
        n_open_elapsed = r_open_elapsed;
        n_beat_elapsed = r_beat_elapsed;
        n_beat_level   = r_beat_level;
        ev             = kdl_pkg::EV_NONE;
        case (i_kind)
            kdl_pkg::KIND_TICK: begin
                if (r_lock == LK_TEMP) begin
                    n_open_elapsed = open_inc;
                    if (open_inc > EW'(i_open_timeout)) begin
                        n_lock = LK_CLOSED;
                        ev     = kdl_pkg::EV_TIMEOUT;
                    end
                end
                n_beat_elapsed = beat_inc;
                if (beat_inc > EW'(i_beat_period)) begin
                    n_beat_elapsed = '0;
                    n_beat_level   = !r_beat_level;
                end
            end
            kdl_pkg::KIND_BUTTON: begin
                if (i_press == kdl_pkg::PRESS_SINGLE) begin
                    if (r_lock == LK_CLOSED) begin
                        n_lock         = LK_TEMP;
                        n_open_elapsed = '0;
                        ev             = kdl_pkg::EV_BUTTON_OPEN;
                    end else if (r_lock == LK_PERM) begin
                        n_lock = LK_CLOSED;
                        ev     = kdl_pkg::EV_BUTTON_CLOSE;
                    end
                end else if (i_press == kdl_pkg::PRESS_DOUBLE) begin
                    n_lock = LK_PERM;
                    ev     = kdl_pkg::EV_BUTTON_PERM;
                end
            end
            kdl_pkg::KIND_KEY, kdl_pkg::KIND_SERIAL: begin
                if (i_judge_fire) begin
                    ev = i_verdict;
                    case (i_verdict)
                        kdl_pkg::EV_DEBUG_OPEN: begin
                            n_lock = LK_PERM;
                        end
                        kdl_pkg::EV_DEBUG_CLOSE: begin
                            n_lock = LK_CLOSED;
                        end
                        kdl_pkg::EV_PASS_OPEN: begin
                            n_lock         = LK_TEMP;
                            n_open_elapsed = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (n_lock)
            LK_TEMP:   o_status.door_mode = kdl_pkg::DOOR_TEMP;
            LK_PERM:   o_status.door_mode = kdl_pkg::DOOR_PERM;
            default:   o_status.door_mode = kdl_pkg::DOOR_CLOSED;
        endcase
        o_status.door_open     = n_lock != LK_CLOSED;
        o_status.event_res     = ev;
        o_status.heartbeat_led = n_beat_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock         <= LK_CLOSED;
            r_open_elapsed <= '0;
            r_beat_elapsed <= '0;
            r_beat_level   <= 1'b0;
        end else if (i_step) begin
            r_lock         <= n_lock;
            r_open_elapsed <= n_open_elapsed;
            r_beat_elapsed <= n_beat_elapsed;
            r_beat_level   <= n_beat_level;
        end
    end

endmodule

`default_nettype wire

### rtl/keypad_door_lock_controller_core.sv
// keypad_door_lock_controller_core: top level of the keypad door lock controller.
// Depends on kdl_pkg, kdl_if, kdl_gather, kdl_match and kdl_ctrl.
//
// Takes one input word per cycle (tick, button event, keypad key or serial character)
// and returns exactly one result word per input word: door state, event code and
// heartbeat level after that word. Each word passes an input register, the state
// update and compare logic, and a result register; a new word can enter every cycle
// while results are taken, and while a result waits the input register holds one
// more word before the input stalls. Config writes are accepted every cycle and
// must only be issued while no word is in flight. No clearing pass after reset.
`default_nettype none

module keypad_door_lock_controller_core #(
    parameter int KEY_DEPTH  = kdl_pkg::KEY_DEPTH_DEF,
    parameter int LINE_DEPTH = kdl_pkg::LINE_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    kdl_item_if.sink      i_item,
    kdl_cfg_if.sink       i_cfg,
    kdl_result_if.source  o_result
);

    logic [63:0] r_pass_chars;
    logic [3:0]  r_pass_len;
    logic [15:0] r_open_timeout;
    logic [15:0] r_beat_period;

    logic                      r_s1_valid;
    kdl_pkg::t_kind            r_s1_kind;
    logic [1:0]                r_s1_press;
    logic [kdl_pkg::SYM_W-1:0] r_s1_sym;

    logic             r_out_valid;
    kdl_pkg::t_status r_out;

    logic                s2_adv;
    logic                step;
    kdl_pkg::t_judge_req key_req;
    kdl_pkg::t_judge_req line_req;
    kdl_pkg::t_judge_req sel_req;
    kdl_pkg::t_event     verdict;
    kdl_pkg::t_status    status;

    assign s2_adv       = !r_out_valid || o_result.ready;
    assign step         = r_s1_valid && s2_adv;
    assign i_item.ready = !r_s1_valid || s2_adv;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_chars   <= '0;
            r_pass_len     <= '0;
            r_open_timeout <= kdl_pkg::OPEN_TIMEOUT_RST;
            r_beat_period  <= kdl_pkg::BEAT_PERIOD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                kdl_pkg::CFG_PASS_CHARS: r_pass_chars   <= i_cfg.wdata;
                kdl_pkg::CFG_PASS_LEN:   r_pass_len     <= i_cfg.wdata[3:0];
                kdl_pkg::CFG_TIMEOUT:    r_open_timeout <= i_cfg.wdata[15:0];
                kdl_pkg::CFG_PERIOD:     r_beat_period  <= i_cfg.wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_s1_kind  <= kdl_pkg::t_kind'(i_item.mode);
            r_s1_press <= i_item.tap_count;
            r_s1_sym   <= i_item.symbol;
        end
    end

    kdl_gather #(
        .DEPTH     (KEY_DEPTH),
        .LINE_MODE (1'b0)
    ) u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_sel   (r_s1_kind == kdl_pkg::KIND_KEY),
        .i_sym   (r_s1_sym),
        .o_req   (key_req)
    );

    kdl_gather #(
        .DEPTH     (LINE_DEPTH),
        .LINE_MODE (1'b1)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_sel   (r_s1_kind == kdl_pkg::KIND_SERIAL),
        .i_sym   (r_s1_sym),
        .o_req   (line_req)
    );

    assign sel_req = (r_s1_kind == kdl_pkg::KIND_KEY) ? key_req : line_req;

    kdl_match u_match (
        .i_req        (sel_req),
        .i_pass_chars (r_pass_chars),
        .i_pass_len   (r_pass_len),
        .o_verdict    (verdict)
    );

    kdl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_kind         (r_s1_kind),
        .i_press        (r_s1_press),
        .i_judge_fire   (sel_req.fire),
        .i_verdict      (verdict),
        .i_open_timeout (r_open_timeout),
        .i_beat_period  (r_beat_period),
        .o_status       (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= status;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.door_open     = r_out.door_open;
    assign o_result.door_mode     = r_out.door_mode;
    assign o_result.event_res     = r_out.event_res;
    assign o_result.heartbeat_led = r_out.heartbeat_led;

endmodule

`default_nettype wire

### rtl/kdl_checker.sv
// kdl_checker: port-level assertions on result words of the door lock controller.
// Depends on kdl_pkg; bound to keypad_door_lock_controller_core below.
`default_nettype none

module kdl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_res_valid,
    input wire logic       i_door_open,
    input wire logic [1:0] i_door_mode,
    input wire logic [3:0] i_event_res
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_open_matches_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_door_open == (i_door_mode != kdl_pkg::DOOR_CLOSED)))
        else $error("door_open disagrees with door_mode");

    a_close_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_event_res == kdl_pkg::EV_TIMEOUT
            || i_event_res == kdl_pkg::EV_DEBUG_CLOSE
            || i_event_res == kdl_pkg::EV_BUTTON_CLOSE))
        |-> (i_door_mode == kdl_pkg::DOOR_CLOSED))
        else $error("closing event with door not closed");

    a_temp_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_event_res == kdl_pkg::EV_PASS_OPEN
            || i_event_res == kdl_pkg::EV_BUTTON_OPEN))
        |-> (i_door_mode == kdl_pkg::DOOR_TEMP))
        else $error("temporary open event with wrong door mode");

    a_perm_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_event_res == kdl_pkg::EV_DEBUG_OPEN
            || i_event_res == kdl_pkg::EV_BUTTON_PERM))
        |-> (i_door_mode == kdl_pkg::DOOR_PERM))
        else $error("permanent open event with wrong door mode");

endmodule

bind keypad_door_lock_controller_core kdl_checker u_kdl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_result.valid),
    .i_door_open (o_result.door_open),
    .i_door_mode (o_result.door_mode),
    .i_event_res (o_result.event_res)
);

`default_nettype wire

### tb/tb_keypad_door_lock_controller_core.sv
// Self-checking testbench for keypad_door_lock_controller_core: directed and random input words
// through valid/ready channels, checked against a cycle-free behavioral predictor.
// Depends on kdl_pkg, kdl_if and the core RTL.
module tb_keypad_door_lock_controller_core;
    import kdl_pkg::*;

    localparam int           QUIET_LIMIT = 2000;
    localparam int           PHASE_WORDS = 225;
    localparam int           KEY_LIMIT   = KEY_DEPTH_DEF - 1;
    localparam int           LINE_LIMIT  = LINE_DEPTH_DEF - 1;
    localparam logic [16:0]  AGE_TOP     = '1;

    typedef logic [7:0] sym_q_t[$];

    class door_scoreboard;
        t_bytes      pass_chars;
        logic [3:0]  pass_len;
        logic [15:0] open_limit;
        logic [15:0] beat_limit;
        t_door       door;
        logic [16:0] open_age;
        logic [16:0] beat_age;
        logic        beat;
        sym_q_t      keys;
        sym_q_t      line;
        t_status     pending_status[$];
        int          errors;
        int          checked;
        int          ev_seen[16];

        function new();
            pass_chars = '0;
            pass_len   = '0;
            open_limit = OPEN_TIMEOUT_RST;
            beat_limit = BEAT_PERIOD_RST;
            door       = DOOR_CLOSED;
            open_age   = '0;
            beat_age   = '0;
            beat       = 1'b0;
            errors     = 0;
            checked    = 0;
            foreach (ev_seen[i]) ev_seen[i] = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [63:0] data);
            case (idx)
                CFG_PASS_CHARS: pass_chars = data;
                CFG_PASS_LEN:   pass_len   = data[3:0];
                CFG_TIMEOUT:    open_limit = data[15:0];
                CFG_PERIOD:     beat_limit = data[15:0];
                default: ;
            endcase
        endfunction

        function bit seq_equals(sym_q_t seq, string text);
            if (seq.size() != text.len()) return 1'b0;
            foreach (seq[i]) if (seq[i] != text[i]) return 1'b0;
            return 1'b1;
        endfunction

        function bit is_code(sym_q_t seq);
            if (pass_len == 0 || pass_len > PASS_MAX || seq.size() != pass_len) return 1'b0;
            foreach (seq[i]) if (seq[i] != pass_chars[i]) return 1'b0;
            return 1'b1;
        endfunction

        function t_event judge_entry(sym_q_t seq);
            if (seq_equals(seq, "#*O*#")) begin
                door = DOOR_PERM;
                return EV_DEBUG_OPEN;
            end
            if (seq_equals(seq, "#*C*#")) begin
                door = DOOR_CLOSED;
                return EV_DEBUG_CLOSE;
            end
            if (is_code(seq)) begin
                door     = DOOR_TEMP;
                open_age = '0;
                return EV_PASS_OPEN;
            end
            return EV_DENIED;
        endfunction

        function void note_word(t_kind kind, logic [1:0] presses, logic [7:0] sym);
            t_event  ev;
            t_status st;
            ev = EV_NONE;
            case (kind)
                KIND_TICK: begin
                    if (door == DOOR_TEMP) begin
                        if (open_age != AGE_TOP) open_age++;
                        if (open_age > {1'b0, open_limit}) begin
                            door = DOOR_CLOSED;
                            ev   = EV_TIMEOUT;
                        end
                    end
                    if (beat_age != AGE_TOP) beat_age++;
                    if (beat_age > {1'b0, beat_limit}) begin
                        beat_age = '0;
                        beat     = ~beat;
                    end
                end
                KIND_BUTTON: begin
                    if (presses == PRESS_SINGLE) begin
                        if (door == DOOR_CLOSED) begin
                            door     = DOOR_TEMP;
                            open_age = '0;
                            ev       = EV_BUTTON_OPEN;
                        end else if (door == DOOR_PERM) begin
                            door = DOOR_CLOSED;
                            ev   = EV_BUTTON_CLOSE;
                        end
                    end else if (presses == PRESS_DOUBLE) begin
                        door = DOOR_PERM;
                        ev   = EV_BUTTON_PERM;
                    end
                end
                KIND_KEY: begin
                    if (keys.size() < KEY_LIMIT) keys.push_back(sym);
                    if (sym == SYM_KEY_TERM || keys.size() >= KEY_LIMIT) begin
                        ev = judge_entry(keys);
                        keys.delete();
                    end
                end
                default: begin
                    if (sym == SYM_CR || sym == SYM_LF) begin
                        if (line.size() > 0) begin
                            ev = judge_entry(line);
                            line.delete();
                        end
                    end else if (line.size() < LINE_LIMIT) begin
                        line.push_back(sym);
                    end
                end
            endcase
            st.door_open     = (door != DOOR_CLOSED);
            st.door_mode     = door;
            st.event_res     = ev;
            st.heartbeat_led = beat;
            pending_status.push_back(st);
        endfunction

        function void check_status(logic door_open, logic [1:0] door_mode, logic [3:0] event_res,
                                   logic heartbeat_led);
            t_status want;
            if (pending_status.size() == 0) begin
                $error("result word with nothing pending");
                errors++;
                return;
            end
            want = pending_status.pop_front();
            checked++;
            ev_seen[want.event_res]++;
            if (door_open !== want.door_open) begin
                $error("door_open: expected %0d, got %0d", want.door_open, door_open);
                errors++;
            end
            if (door_mode !== want.door_mode) begin
                $error("door_mode: expected %0d, got %0d", want.door_mode, door_mode);
                errors++;
            end
            if (event_res !== want.event_res) begin
                $error("event_res: expected %0d, got %0d", want.event_res, event_res);
                errors++;
            end
            if (heartbeat_led !== want.heartbeat_led) begin
                $error("heartbeat_led: expected %0d, got %0d", want.heartbeat_led, heartbeat_led);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    kdl_item_if   item_bus ();
    kdl_cfg_if    cfg_bus ();
    kdl_result_if status_bus ();

    keypad_door_lock_controller_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (status_bus)
    );

    door_scoreboard sb = new();

    int     send_idle;
    int     recv_stall;
    int     sent_words;
    int     quiet_cycles;
    t_bytes cur_code;
    int     cur_len;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        status_bus.ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_reg(t_cfg_idx'(cfg_bus.reg_index), cfg_bus.wdata);
            if (item_bus.valid && item_bus.ready)
                sb.note_word(t_kind'(item_bus.mode), item_bus.tap_count, item_bus.symbol);
            if (status_bus.valid && status_bus.ready)
                sb.check_status(status_bus.door_open, status_bus.door_mode, status_bus.event_res,
                                status_bus.heartbeat_led);
        end
        if ((cfg_bus.valid && cfg_bus.ready) || (item_bus.valid && item_bus.ready) ||
            (status_bus.valid && status_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic logic [7:0] plain_sym();
        logic [7:0] s;
        do s = 8'($urandom_range(255));
        while (s == SYM_KEY_TERM || s == SYM_CR || s == SYM_LF);
        return s;
    endfunction

    function automatic sym_q_t text_seq(string text);
        sym_q_t seq;
        for (int i = 0; i < text.len(); i++) seq.push_back(text[i]);
        return seq;
    endfunction

    function automatic sym_q_t code_seq(bit flip);
        sym_q_t seq;
        int     n;
        n = (cur_len > PASS_MAX) ? PASS_MAX : cur_len;
        for (int i = 0; i < n; i++) seq.push_back(cur_code[i]);
        if (flip && n > 0) seq[$urandom_range(n - 1)] ^= 8'(1 << $urandom_range(7));
        return seq;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(t_kind kind, logic [1:0] presses, logic [7:0] sym);
        while ($urandom_range(99) < send_idle) begin
            item_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid     <= 1'b1;
        item_bus.mode      <= kind;
        item_bus.tap_count <= presses;
        item_bus.symbol    <= sym;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (kind != KIND_BUTTON || presses == PRESS_SINGLE || presses == PRESS_DOUBLE)
            sent_words++;
    endtask

    task automatic send_seq(t_kind kind, sym_q_t seq);
        foreach (seq[i]) send_word(kind, 2'($urandom_range(3)), seq[i]);
    endtask

    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        do @(negedge i_clk);
        while (sb.pending_status.size() != 0);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wdata     <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic configure(t_bytes code, int len, logic [15:0] tmo, logic [15:0] period);
        write_reg(CFG_PASS_CHARS, code);
        write_reg(CFG_PASS_LEN, 64'(len));
        write_reg(CFG_TIMEOUT, 64'(tmo));
        write_reg(CFG_PERIOD, 64'(period));
        cfg_bus.valid <= 1'b0;
        cur_code = code;
        cur_len  = len;
    endtask

    task automatic random_burst();
        sym_q_t seq;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            repeat ($urandom_range(8, 1))
                send_word(KIND_TICK, 2'($urandom_range(3)), 8'($urandom_range(255)));
        end else if (pick < 45) begin
            if ($urandom_range(4) == 0)
                send_word(KIND_BUTTON, $urandom_range(1) ? 2'd0 : 2'd3, 8'($urandom_range(255)));
            else
                send_word(KIND_BUTTON, $urandom_range(1) ? PRESS_SINGLE : PRESS_DOUBLE,
                          8'($urandom_range(255)));
        end else if (pick < 65) begin
            case ($urandom_range(4))
                0, 1: seq = code_seq(1'b0);
                2: repeat ($urandom_range(6)) seq.push_back(plain_sym());
                3: repeat (KEY_LIMIT) seq.push_back(plain_sym());
                default: seq = code_seq(1'b1);
            endcase
            if (seq.size() < KEY_LIMIT && (seq.size() == 0 || seq[seq.size() - 1] != SYM_KEY_TERM))
                seq.push_back(SYM_KEY_TERM);
            send_seq(KIND_KEY, seq);
        end else if (pick < 92) begin
            case ($urandom_range(6))
                0, 1: seq = code_seq(1'b0);
                2: seq = text_seq("#*O*#");
                3: seq = text_seq("#*C*#");
                4: repeat ($urandom_range(10)) seq.push_back(plain_sym());
                5: repeat ($urandom_range(40, LINE_LIMIT)) seq.push_back(plain_sym());
                default: seq = code_seq(1'b1);
            endcase
            seq.push_back($urandom_range(1) ? SYM_CR : SYM_LF);
            send_seq(KIND_SERIAL, seq);
        end else begin
            repeat ($urandom_range(3, 1))
                send_word(t_kind'($urandom_range(3)), 2'($urandom_range(3)),
                          8'($urandom_range(255)));
        end
    endtask

    initial begin
        t_bytes code;
        int     len;
        int     goal;
        item_bus.valid       = 1'b0;
        item_bus.mode        = KIND_TICK;
        item_bus.tap_count   = '0;
        item_bus.symbol      = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.reg_index    = CFG_PASS_CHARS;
        cfg_bus.wdata        = '0;
        status_bus.ready     = 1'b1;
        send_idle            = 0;
        recv_stall           = 0;
        sent_words           = 0;
        quiet_cycles         = 0;
        i_rst_n              = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: code "12#", fast timeout and heartbeat
        configure(t_bytes'(64'h23_32_31), 3, 16'd2, 16'd1);
        send_word(KIND_BUTTON, 2'd0, 8'h00);
        send_word(KIND_BUTTON, 2'd3, 8'hFF);
        send_word(KIND_BUTTON, PRESS_SINGLE, 8'h00);
        send_word(KIND_BUTTON, PRESS_SINGLE, 8'hFF);
        repeat (3) send_word(KIND_TICK, 2'd0, 8'h00);
        send_word(KIND_BUTTON, PRESS_DOUBLE, 8'h00);
        send_word(KIND_BUTTON, PRESS_DOUBLE, 8'h00);
        send_word(KIND_BUTTON, PRESS_SINGLE, 8'h00);
        send_word(KIND_KEY, 2'd3, SYM_KEY_TERM);
        send_word(KIND_SERIAL, 2'd0, SYM_LF);
        send_seq(KIND_SERIAL, text_seq("#*O*#"));
        send_word(KIND_SERIAL, 2'd0, SYM_CR);
        send_seq(KIND_KEY, text_seq("12#"));
        send_word(KIND_SERIAL, 2'd1, 8'h00);
        send_word(KIND_SERIAL, 2'd2, 8'hFF);
        send_word(KIND_SERIAL, 2'd3, SYM_LF);
        send_seq(KIND_SERIAL, text_seq("#*C*#"));
        send_word(KIND_SERIAL, 2'd0, SYM_LF);

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            foreach (code[i]) code[i] = plain_sym();
            len = $urandom_range(PASS_MAX, 1);
            case (ph)
                0: begin
                    send_idle = 0;  recv_stall = 0;
                    configure(t_bytes'(64'h23_32_31), 3, 16'd3, 16'd2);
                end
                1: begin
                    send_idle = 84; recv_stall = 0;
                    configure('1, PASS_MAX, 16'd0, 16'd0);
                end
                2: begin
                    send_idle = 0;  recv_stall = 84;
                    configure('0, PASS_MAX, 16'hFFFF, 16'hFFFF);
                end
                3: begin
                    send_idle = 24; recv_stall = 24;
                    configure(code, 15, 16'd5, 16'd7);
                end
                4: begin
                    send_idle = 0;  recv_stall = 0;
                    code[len - 1] = SYM_KEY_TERM;
                    configure(code, len, 16'd1, 16'd3);
                end
                default: begin
                    send_idle = 24; recv_stall = 24;
                    configure(code, 0, 16'd12, 16'd1);
                end
            endcase
            goal = sent_words + PHASE_WORDS;
            while (sent_words < goal) begin
                random_burst();
                if ($urandom_range(149) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.pending_status.size() != 0) begin
            $error("%0d result words never arrived", sb.pending_status.size());
            sb.errors++;
        end
        $display("%0d input words, %0d results checked over seven register settings",
                 sent_words, sb.checked);
        $display("code opens %0d, debug %0d/%0d, button %0d/%0d/%0d, denied %0d, timeouts %0d",
                 sb.ev_seen[EV_PASS_OPEN], sb.ev_seen[EV_DEBUG_OPEN], sb.ev_seen[EV_DEBUG_CLOSE],
                 sb.ev_seen[EV_BUTTON_OPEN], sb.ev_seen[EV_BUTTON_CLOSE],
                 sb.ev_seen[EV_BUTTON_PERM], sb.ev_seen[EV_DENIED], sb.ev_seen[EV_TIMEOUT]);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### keypad_door_lock_controller_core.f
rtl/kdl_pkg.sv
rtl/kdl_if.sv
rtl/kdl_gather.sv
rtl/kdl_match.sv
rtl/kdl_ctrl.sv
rtl/keypad_door_lock_controller_core.sv
rtl/kdl_checker.sv
tb/tb_keypad_door_lock_controller_core.sv
